// ===== hw/rtl/mwf_pkg.sv =====
// ----------------------------------------------------------------------------
// mwf_pkg
// Shared types and constants of the wall-following maze walker.
// ----------------------------------------------------------------------------
`default_nettype none

package mwf_pkg;

  // grid cells in use along each side, the map itself is always 16 x 16
  localparam int MAZE_DIM  = 16;
  localparam int SIDE      = 16;
  localparam int COORD_W   = 4;
  localparam int DIM_W     = 7;
  localparam int MAP_DEPTH = SIDE * SIDE;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int STEP_W    = 16;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [COORD_W-1:0] EXIT_ROW_RST  = COORD_W'(4);
  localparam logic [COORD_W-1:0] EXIT_COL_RST  = COORD_W'(11);
  localparam logic [STEP_W-1:0]  STEP_MAX      = {STEP_W{1'b1}};

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [1:0]         dir_t;

  localparam dir_t HEADING_RST = 2'd0;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STAT_MOVED   = 3'd0,
    STAT_EXIT    = 3'd1,
    STAT_BLOCKED = 3'd2,
    STAT_REJECT  = 3'd3,
    STAT_DONE    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_EXIT_ROW      = 2'd0,
    REG_EXIT_COL      = 2'd1,
    REG_START_HEADING = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_NBR,
    S_TURN
  } state_t;

  typedef struct packed {
    coord_t exit_row;
    coord_t exit_col;
    dir_t   start_heading;
  } cfg_t;

  // one access to the wall map
  typedef struct packed {
    logic   rd;
    logic   wr;
    logic   off;
    coord_t row;
    coord_t col;
    logic   wdata;
  } map_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/maze_wall_follower_unit.sv =====
// ----------------------------------------------------------------------------
// maze_wall_follower_unit
// Right-hand wall follower over a 16 x 16 wall map held in a RAM.
//
//   channel   handshake              payload
//   input     start / busy           in_opcode, in_cell_row, in_cell_col,
//                                    in_cell_is_wall
//   result    out_strobe (1 cycle)   out_status, out_walker_row,
//                                    out_walker_col, out_walker_heading,
//                                    out_step_total
//   config    psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// a load, an unused opcode or a step at the exit ends in the idle state, a
// start in S_START, a step after four neighbor wall reads through the single
// map port and the turn-and-move S_TURN. the beat follows in the next cycle.
// reset puts every cell back to wall at once through per-cell valid bits;
// no clearing pass. the result beat cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module maze_wall_follower_unit
  import mwf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [3:0]        in_cell_row,
  input  wire logic [3:0]        in_cell_col,
  input  wire logic              in_cell_is_wall,
  output logic                   out_strobe,
  output logic [2:0]             out_status,
  output logic [3:0]             out_walker_row,
  output logic [3:0]             out_walker_col,
  output logic [1:0]             out_walker_heading,
  output logic [15:0]            out_step_total,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t     cfg;
  map_req_t map_req;
  logic     map_wall;

  mwf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mwf_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (map_req),
    .wall  (map_wall)
  );

  mwf_walker u_walker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_cell_row        (in_cell_row),
    .in_cell_col        (in_cell_col),
    .in_cell_is_wall    (in_cell_is_wall),
    .map_req            (map_req),
    .map_wall           (map_wall),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_walker_row     (out_walker_row),
    .out_walker_col     (out_walker_col),
    .out_walker_heading (out_walker_heading),
    .out_step_total     (out_step_total)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mwf_ram.sv =====
// ----------------------------------------------------------------------------
// mwf_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mwf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mwf_map.sv =====
// ----------------------------------------------------------------------------
// mwf_map
// Wall map: one bit per cell in a RAM, valid bits so unwritten cells read as
// walls, and off-grid cells forced to walls.
// ----------------------------------------------------------------------------
`default_nettype none

module mwf_map
  import mwf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire map_req_t req,
  output logic          wall
);

  logic [MAP_DEPTH-1:0] valid_r;
  logic [MAP_DEPTH-1:0] valid_nxt;
  logic                 valid_q_r;
  logic                 off_q_r;
  logic                 ram_q;
  logic                 off_grid;
  logic [MAP_AW-1:0]    addr;

  assign off_grid = req.off
                  || ({{(DIM_W-COORD_W){1'b0}}, req.row} >= DIM_W'(MAZE_DIM))
                  || ({{(DIM_W-COORD_W){1'b0}}, req.col} >= DIM_W'(MAZE_DIM));
  assign addr = {req.row, req.col};

  mwf_ram #(
    .WIDTH (1),
    .DEPTH (MAP_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    ((req.rd || req.wr) && !off_grid),
    .we    (req.wr),
    .addr  (addr),
    .wdata (req.wdata),
    .rdata (ram_q)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (req.wr && !off_grid) begin
      valid_nxt[addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      off_q_r   <= off_grid;
      valid_q_r <= valid_r[addr];
    end
  end

  // never-written cells keep their reset value: wall
  assign wall = off_q_r || !valid_q_r || ram_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mwf_cfg.sv =====
// ----------------------------------------------------------------------------
// mwf_cfg
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module mwf_cfg
  import mwf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_EXIT_ROW:      cfg_nxt.exit_row      = pwdata[COORD_W-1:0];
        REG_EXIT_COL:      cfg_nxt.exit_col      = pwdata[COORD_W-1:0];
        REG_START_HEADING: cfg_nxt.start_heading = pwdata[1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.exit_row      <= EXIT_ROW_RST;
      cfg_r.exit_col      <= EXIT_COL_RST;
      cfg_r.start_heading <= HEADING_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_EXIT_ROW:      prdata = {{(DATA_W-COORD_W){1'b0}}, cfg_r.exit_row};
      REG_EXIT_COL:      prdata = {{(DATA_W-COORD_W){1'b0}}, cfg_r.exit_col};
      REG_START_HEADING: prdata = {{(DATA_W-2){1'b0}}, cfg_r.start_heading};
      default:           prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mwf_walker.sv =====
// ----------------------------------------------------------------------------
// mwf_walker
// Command sequencer: walker position, heading and step count, wall map
// accesses and the turn rules.
// ----------------------------------------------------------------------------
`default_nettype none

module mwf_walker
  import mwf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cfg_t          cfg,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    in_opcode,
  input  wire coord_t        in_cell_row,
  input  wire coord_t        in_cell_col,
  input  wire logic          in_cell_is_wall,
  output map_req_t           map_req,
  input  wire logic          map_wall,
  output logic               out_strobe,
  output logic [2:0]         out_status,
  output coord_t             out_walker_row,
  output coord_t             out_walker_col,
  output dir_t               out_walker_heading,
  output logic [STEP_W-1:0]  out_step_total
);

  state_t              state_r, state_nxt;
  coord_t              pos_row_r, pos_row_nxt;
  coord_t              pos_col_r, pos_col_nxt;
  dir_t                heading_r, heading_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  coord_t              cell_row_r, cell_col_r;
  dir_t                cnt_r, cnt_nxt;
  logic [2:0]          walls_r, walls_nxt;
  logic                strobe_r;
  status_t             status_r, status_nxt;
  coord_t              o_row_r, o_col_r;
  dir_t                o_head_r;
  logic [STEP_W-1:0]   o_step_r;
  logic                accept;
  logic                at_exit;
  logic                fin;
  opcode_t             op;
  logic [3:0]          walls_all;
  dir_t                turn_dir;
  map_req_t            nbr_req;
  map_req_t            move_req;

  // neighbor cell in a direction, off set where it falls off the grid
  function automatic map_req_t nbr(coord_t row, coord_t col, dir_t d);
    map_req_t r;
    r       = '0;
    r.rd    = 1'b1;
    r.row   = row;
    r.col   = col;
    case (d)
      2'd0: begin
        r.off = (row == '0);
        r.row = row - COORD_W'(1);
      end
      2'd1: begin
        r.off = (col == '1);
        r.col = col + COORD_W'(1);
      end
      2'd2: begin
        r.off = (row == '1);
        r.row = row + COORD_W'(1);
      end
      default: begin
        r.off = (col == '0);
        r.col = col - COORD_W'(1);
      end
    endcase
    return r;
  endfunction

  // the three ordered neighbor rules
  function automatic dir_t turn(logic [3:0] w, dir_t d0);
    dir_t d;
    d = d0;
    if (w[d] && w[d + 2'd1]) begin
      d = w[d + 2'd3] ? d + 2'd2 : d + 2'd3;
    end
    if (!w[d] && !w[d + 2'd1]) begin
      d = d + 2'd1;
    end
    if (w[d] && !w[d + 2'd1]) begin
      d = d + 2'd1;
    end
    return d;
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign op        = opcode_t'(in_opcode);
  assign at_exit   = (pos_row_r == cfg.exit_row) && (pos_col_r == cfg.exit_col);
  assign walls_all = {map_wall, walls_r};
  assign turn_dir  = turn(walls_all, heading_r);
  assign nbr_req   = nbr(pos_row_r, pos_col_r, (state_r == S_IDLE) ? 2'd0 : cnt_r);
  assign move_req  = nbr(pos_row_r, pos_col_r, turn_dir);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_START: state_nxt = S_START;
            OP_STEP:  state_nxt = at_exit ? S_IDLE : S_NBR;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_START: state_nxt = S_IDLE;
      S_NBR:   state_nxt = (cnt_r == 2'd3) ? S_TURN : S_NBR;
      S_TURN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // map accesses and walker updates
  always_comb begin
    map_req     = '0;
    pos_row_nxt = pos_row_r;
    pos_col_nxt = pos_col_r;
    heading_nxt = heading_r;
    step_nxt    = step_r;
    cnt_nxt     = cnt_r;
    walls_nxt   = walls_r;
    fin         = 1'b0;
    status_nxt  = STAT_DONE;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_LOAD: begin
              map_req.wr    = 1'b1;
              map_req.row   = in_cell_row;
              map_req.col   = in_cell_col;
              map_req.wdata = in_cell_is_wall;
              fin           = 1'b1;
            end
            OP_START: begin
              map_req.rd  = 1'b1;
              map_req.row = in_cell_row;
              map_req.col = in_cell_col;
            end
            OP_STEP: begin
              if (at_exit) begin
                fin        = 1'b1;
                status_nxt = STAT_EXIT;
              end else begin
                map_req = nbr_req;
                cnt_nxt = 2'd1;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_START: begin
        fin = 1'b1;
        if (map_wall) begin
          status_nxt = STAT_REJECT;
        end else begin
          pos_row_nxt = cell_row_r;
          pos_col_nxt = cell_col_r;
          heading_nxt = cfg.start_heading;
          step_nxt    = '0;
        end
      end
      S_NBR: begin
        // data of the previous direction's read lands this cycle
        walls_nxt[cnt_r - 2'd1] = map_wall;
        map_req                 = nbr_req;
        cnt_nxt                 = cnt_r + 2'd1;
      end
      S_TURN: begin
        fin         = 1'b1;
        heading_nxt = turn_dir;
        if (walls_all[turn_dir]) begin
          status_nxt = STAT_BLOCKED;
        end else begin
          status_nxt  = STAT_MOVED;
          pos_row_nxt = move_req.row;
          pos_col_nxt = move_req.col;
          if (step_r != STEP_MAX) begin
            step_nxt = step_r + STEP_W'(1);
          end
        end
      end
      default: fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pos_row_r <= '0;
      pos_col_r <= '0;
      heading_r <= HEADING_RST;
      step_r    <= '0;
      strobe_r  <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      pos_row_r <= pos_row_nxt;
      pos_col_r <= pos_col_nxt;
      heading_r <= heading_nxt;
      step_r    <= step_nxt;
      strobe_r  <= fin;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walls_r <= walls_nxt;
    if (accept) begin
      cell_row_r <= in_cell_row;
      cell_col_r <= in_cell_col;
    end
    if (fin) begin
      status_r <= status_nxt;
      o_row_r  <= pos_row_nxt;
      o_col_r  <= pos_col_nxt;
      o_head_r <= heading_nxt;
      o_step_r <= step_nxt;
    end
  end

  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_walker_row     = o_row_r;
  assign out_walker_col     = o_col_r;
  assign out_walker_heading = o_head_r;
  assign out_step_total     = o_step_r;

endmodule

`default_nettype wire

// ===== verif/maze_wall_follower_unit_tb.sv =====
// ----------------------------------------------------------------------------
// maze_wall_follower_unit_tb
// Feeds load, start and step commands to the maze walker and keeps its own
// copy of the wall map, the walker and the exit registers. Every result beat
// is compared field by field with the oldest predicted one. The exit and
// heading registers are written and read back only while the walker is idle.
// ----------------------------------------------------------------------------

module maze_wall_follower_unit_tb;
  import mwf_pkg::*;

  localparam int ITEMS_RANDOM = 1400;
  localparam int LOOP_STEPS   = 64;
  localparam int CYCLE_LIMIT  = 2_500_000;
  localparam int SETTLE_LIMIT = 2000;
  localparam int TAIL_CYCLES  = 8;
  localparam int MAX_PRINTED  = 30;

  localparam dir_t HEAD_UP    = 2'd0;
  localparam dir_t HEAD_RIGHT = 2'd1;
  localparam dir_t HEAD_DOWN  = 2'd2;
  localparam dir_t HEAD_LEFT  = 2'd3;

  typedef struct packed {
    status_t           status;
    coord_t            row;
    coord_t            col;
    dir_t              heading;
    logic [STEP_W-1:0] steps;
  } walk_result_t;

  class walk_scoreboard;
    bit                wall_map [SIDE][SIDE];
    coord_t            pos_row;
    coord_t            pos_col;
    dir_t              heading;
    logic [STEP_W-1:0] steps;
    cfg_t              cfg;
    walk_result_t      walk_q [$];
    int                mismatches;
    int                checked;
    int                op_seen [4];
    int                status_seen [8];
    bit                saturated;

    function new();
      foreach (wall_map[r, c]) wall_map[r][c] = 1'b1;
      pos_row           = '0;
      pos_col           = '0;
      heading           = HEADING_RST;
      steps             = '0;
      cfg.exit_row      = EXIT_ROW_RST;
      cfg.exit_col      = EXIT_COL_RST;
      cfg.start_heading = HEADING_RST;
    endfunction

    function int pending();
      return walk_q.size();
    endfunction

    function int commands();
      return op_seen[int'(OP_LOAD)] + op_seen[int'(OP_START)] + op_seen[int'(OP_STEP)];
    endfunction

    // anything off the map counts as wall
    function bit wall_at(int r, int c);
      if (r < 0 || c < 0 || r >= MAZE_DIM || c >= MAZE_DIM) return 1'b1;
      return wall_map[r][c];
    endfunction

    function void cell_ahead(dir_t d, output int r, output int c);
      r = pos_row;
      c = pos_col;
      case (d)
        HEAD_UP:    r = r - 1;
        HEAD_RIGHT: c = c + 1;
        HEAD_DOWN:  r = r + 1;
        default:    c = c - 1;
      endcase
    endfunction

    function bit wall_toward(dir_t d);
      int r;
      int c;
      cell_ahead(d, r, c);
      return wall_at(r, c);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("[%0t] error: %s", $time, what);
    endtask

    function void note_item(opcode_t op, coord_t r, coord_t c, logic w);
      walk_result_t res;
      status_t      st;
      dir_t         d;
      int           nr;
      int           nc;
      st = STAT_DONE;
      case (op)
        OP_LOAD: begin
          if (r < MAZE_DIM && c < MAZE_DIM) wall_map[r][c] = w;
        end
        OP_START: begin
          if (wall_at(r, c)) begin
            st = STAT_REJECT;
          end else begin
            pos_row = r;
            pos_col = c;
            heading = cfg.start_heading;
            steps   = '0;
          end
        end
        OP_STEP: begin
          if (pos_row == cfg.exit_row && pos_col == cfg.exit_col) begin
            st = STAT_EXIT;
          end else begin
            d = heading;
            // closed ahead and right: turn left, or back if left is closed too
            if (wall_toward(d) && wall_toward(d + 2'd1))
              d = wall_toward(d + 2'd3) ? d + 2'd2 : d + 2'd3;
            if (!wall_toward(d) && !wall_toward(d + 2'd1)) d = d + 2'd1;
            if (wall_toward(d) && !wall_toward(d + 2'd1)) d = d + 2'd1;
            heading = d;
            cell_ahead(d, nr, nc);
            if (wall_at(nr, nc)) begin
              st = STAT_BLOCKED;
            end else begin
              pos_row = coord_t'(nr);
              pos_col = coord_t'(nc);
              if (steps != STEP_MAX) steps = steps + 1'b1;
              if (steps == STEP_MAX) saturated = 1'b1;
              st = STAT_MOVED;
            end
          end
        end
        default: ;
      endcase
      op_seen[int'(op)]++;
      status_seen[int'(st)]++;
      res.status  = st;
      res.row     = pos_row;
      res.col     = pos_col;
      res.heading = heading;
      res.steps   = steps;
      walk_q.push_back(res);
    endfunction

    task check_result(logic [2:0] st, coord_t r, coord_t c, dir_t h, logic [STEP_W-1:0] n);
      walk_result_t want;
      if (walk_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
        return;
      end
      want = walk_q.pop_front();
      checked++;
      if (st !== want.status)
        report_mismatch($sformatf("result %0d: status %0d, expected %0d", checked, st,
                                  want.status));
      if (r !== want.row)
        report_mismatch($sformatf("result %0d: row %0d, expected %0d", checked, r, want.row));
      if (c !== want.col)
        report_mismatch($sformatf("result %0d: col %0d, expected %0d", checked, c, want.col));
      if (h !== want.heading)
        report_mismatch($sformatf("result %0d: heading %0d, expected %0d", checked, h,
                                  want.heading));
      if (n !== want.steps)
        report_mismatch($sformatf("result %0d: step total %0d, expected %0d", checked, n,
                                  want.steps));
    endtask

    task flush_leftovers();
      if (walk_q.size() != 0) begin
        report_mismatch($sformatf("%0d expected results never came", walk_q.size()));
        walk_q.delete();
      end
    endtask
  endclass

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              start           = 1'b0;
  logic              busy;
  logic [1:0]        in_opcode       = '0;
  logic [3:0]        in_cell_row     = '0;
  logic [3:0]        in_cell_col     = '0;
  logic              in_cell_is_wall = 1'b0;
  logic              out_strobe;
  logic [2:0]        out_status;
  logic [3:0]        out_walker_row;
  logic [3:0]        out_walker_col;
  logic [1:0]        out_walker_heading;
  logic [15:0]       out_step_total;
  logic              psel            = 1'b0;
  logic              penable         = 1'b0;
  logic              pwrite          = 1'b0;
  logic [ADDR_W-1:0] paddr           = '0;
  logic [DATA_W-1:0] pwdata          = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  walk_scoreboard sb;
  bit             idling_on   = 1'b1;
  int             cycle_count = 0;

  maze_wall_follower_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_cell_row        (in_cell_row),
    .in_cell_col        (in_cell_col),
    .in_cell_is_wall    (in_cell_is_wall),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_walker_row     (out_walker_row),
    .out_walker_col     (out_walker_col),
    .out_walker_heading (out_walker_heading),
    .out_step_total     (out_step_total),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout: run stopped at the cycle limit");
    $display("Mismatches found");
    $finish;
  end

  // result beats cannot be held off, so every strobe is taken as it comes
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1)
      sb.check_result(out_status, out_walker_row, out_walker_col, out_walker_heading,
                      out_step_total);
    else if (rst_n && out_strobe !== 1'b0)
      sb.report_mismatch("result strobe is unknown");
  end

  task automatic send_item(opcode_t op, coord_t r, coord_t c, logic w);
    start           <= 1'b1;
    in_opcode       <= op;
    in_cell_row     <= r;
    in_cell_col     <= c;
    in_cell_is_wall <= w;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(op, r, c, w);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start           <= 1'b0;
      in_opcode       <= 2'($urandom_range(0, 3));
      in_cell_row     <= 4'($urandom_range(0, 15));
      in_cell_col     <= 4'($urandom_range(0, 15));
      in_cell_is_wall <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // any opcode, any cell: breaks up well-formed sequences
  task automatic send_noise();
    send_item(opcode_t'($urandom_range(0, 3)), coord_t'($urandom_range(0, 15)),
              coord_t'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  task automatic settle();
    int waited;
    start  <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (sb.pending() != 0 && waited < SETTLE_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.flush_leftovers();
  endtask

  task automatic cfg_access(reg_idx_t idx, logic wr, logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(reg_idx_t idx);
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] want;
    logic [DATA_W-1:0] keep;
    cfg_access(idx, 1'b0, '0, rd);
    keep = (idx == REG_START_HEADING) ? DATA_W'(2'b11) : DATA_W'(4'hF);
    case (idx)
      REG_EXIT_ROW: want = DATA_W'(sb.cfg.exit_row);
      REG_EXIT_COL: want = DATA_W'(sb.cfg.exit_col);
      default:      want = DATA_W'(sb.cfg.start_heading);
    endcase
    if ((rd & keep) !== want)
      sb.report_mismatch($sformatf("register %s reads %0h, expected %0h", idx.name(), rd,
                                   want));
  endtask

  task automatic set_reg(reg_idx_t idx, int val);
    logic [DATA_W-1:0] rd;
    cfg_access(idx, 1'b1, DATA_W'(val), rd);
    case (idx)
      REG_EXIT_ROW: sb.cfg.exit_row = coord_t'(val);
      REG_EXIT_COL: sb.cfg.exit_col = coord_t'(val);
      default:      sb.cfg.start_heading = dir_t'(val);
    endcase
    check_reg(idx);
  endtask

  initial begin
    int     directed_items;
    int     ep;
    int     w;
    int     base_r;
    int     base_c;
    int     density;
    int     n_loads;
    int     n_steps;
    int     tries;
    int     nr;
    int     nc;
    int     pick;
    bit     found;
    coord_t r;
    coord_t c;

    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_reg(REG_EXIT_ROW);
    check_reg(REG_EXIT_COL);
    check_reg(REG_START_HEADING);

    // step before any start, everything still wall
    send_item(OP_STEP, '0, '0, 1'b0);
    send_item(OP_START, 4'd5, 4'd5, 1'b0);
    send_item(OP_NONE, 4'd15, 4'd15, 1'b1);
    // walk away from the reset corner along the top and left edges
    send_item(OP_LOAD, 4'd0, 4'd1, 1'b0);
    send_item(OP_LOAD, 4'd1, 4'd0, 1'b0);
    send_item(OP_STEP, '0, '0, 1'b0);
    send_item(OP_STEP, '0, '0, 1'b0);
    // far corner, off-grid on the bottom and right
    send_item(OP_LOAD, 4'd15, 4'd15, 1'b0);
    send_item(OP_LOAD, 4'd15, 4'd14, 1'b0);
    send_item(OP_START, 4'd15, 4'd15, 1'b0);
    send_item(OP_STEP, 4'd15, 4'd15, 1'b1);
    send_item(OP_STEP, 4'd15, 4'd15, 1'b1);
    // boxed in on a lone open cell
    send_item(OP_LOAD, 4'd8, 4'd8, 1'b0);
    send_item(OP_START, 4'd8, 4'd8, 1'b0);
    send_item(OP_STEP, '0, '0, 1'b0);
    send_item(OP_STEP, '0, '0, 1'b0);
    // start on the exit, then stay there
    send_item(OP_LOAD, EXIT_ROW_RST, EXIT_COL_RST, 1'b0);
    send_item(OP_START, EXIT_ROW_RST, EXIT_COL_RST, 1'b0);
    send_item(OP_STEP, '0, '0, 1'b0);
    send_item(OP_STEP, '0, '0, 1'b0);
    // close the exit again and try to start there
    send_item(OP_LOAD, EXIT_ROW_RST, EXIT_COL_RST, 1'b1);
    send_item(OP_START, EXIT_ROW_RST, EXIT_COL_RST, 1'b0);
    directed_items = sb.commands();

    ep = 0;
    while (sb.commands() - directed_items < ITEMS_RANDOM) begin
      if (ep < 4 || $urandom_range(0, 4) == 0) begin
        settle();
        if (ep < 4) begin
          // exit in each corner, each start heading once
          set_reg(REG_EXIT_ROW, ep[0] ? SIDE - 1 : 0);
          set_reg(REG_EXIT_COL, ep[1] ? SIDE - 1 : 0);
          set_reg(REG_START_HEADING, ep);
        end else begin
          set_reg(REG_EXIT_ROW, $urandom_range(0, SIDE - 1));
          set_reg(REG_EXIT_COL, $urandom_range(0, SIDE - 1));
          set_reg(REG_START_HEADING, $urandom_range(0, 3));
        end
      end else if ($urandom_range(0, 5) == 0) begin
        settle();
      end
      idling_on = ($urandom_range(0, 9) < 7);

      // a small patch of maze, often on an edge or around the exit
      w = $urandom_range(3, 8);
      case ($urandom_range(0, 3))
        0: begin
          base_r = $urandom_range(0, 1) ? 0 : SIDE - w;
          base_c = $urandom_range(0, 1) ? 0 : SIDE - w;
        end
        1: begin
          base_r = int'(sb.cfg.exit_row) - w / 2;
          base_c = int'(sb.cfg.exit_col) - w / 2;
        end
        default: begin
          base_r = $urandom_range(0, SIDE - w);
          base_c = $urandom_range(0, SIDE - w);
        end
      endcase
      if (base_r < 0) base_r = 0;
      if (base_r > SIDE - w) base_r = SIDE - w;
      if (base_c < 0) base_c = 0;
      if (base_c > SIDE - w) base_c = SIDE - w;

      density = $urandom_range(20, 55);
      n_loads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4)
                                            : $urandom_range(w * w / 2, w * w);
      repeat (n_loads) begin
        if ($urandom_range(0, 24) == 0) send_noise();
        send_item(OP_LOAD, coord_t'(base_r + $urandom_range(0, w - 1)),
                  coord_t'(base_c + $urandom_range(0, w - 1)),
                  ($urandom_range(0, 99) < density));
      end

      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        found = 1'b0;
        for (tries = 0; tries < 30 && !found; tries++) begin
          r     = coord_t'(base_r + $urandom_range(0, w - 1));
          c     = coord_t'(base_c + $urandom_range(0, w - 1));
          found = !sb.wall_map[r][c];
        end
        send_item(OP_START, r, c, 1'($urandom_range(0, 1)));
      end else if (pick < 85) begin
        // open the exit and a neighbor of it, start next to the exit (on it if off-grid)
        r = sb.cfg.exit_row;
        c = sb.cfg.exit_col;
        send_item(OP_LOAD, r, c, 1'b0);
        nr = r;
        nc = c;
        case (dir_t'($urandom_range(0, 3)))
          HEAD_UP:    nr = nr - 1;
          HEAD_RIGHT: nc = nc + 1;
          HEAD_DOWN:  nr = nr + 1;
          default:    nc = nc - 1;
        endcase
        if (nr >= 0 && nr < SIDE && nc >= 0 && nc < SIDE) begin
          r = coord_t'(nr);
          c = coord_t'(nc);
          send_item(OP_LOAD, r, c, 1'b0);
        end
        send_item(OP_START, r, c, 1'b0);
      end else begin
        send_item(OP_START, coord_t'($urandom_range(0, 15)), coord_t'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)));
      end

      n_steps = $urandom_range(10, 60);
      repeat (n_steps) begin
        if ($urandom_range(0, 24) == 0) send_noise();
        send_item(OP_STEP, coord_t'($urandom_range(0, 15)), coord_t'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)));
      end
      ep++;
    end

    // keep circling a 2 x 2 room, back to back with no idling
    settle();
    set_reg(REG_EXIT_ROW, 0);
    set_reg(REG_EXIT_COL, SIDE - 1);
    set_reg(REG_START_HEADING, HEAD_RIGHT);
    idling_on = 1'b0;
    for (nr = 8; nr <= 11; nr++) begin
      for (nc = 2; nc <= 5; nc++) begin
        send_item(OP_LOAD, coord_t'(nr), coord_t'(nc),
                  !(nr >= 9 && nr <= 10 && nc >= 3 && nc <= 4));
      end
    end
    send_item(OP_START, 4'd9, 4'd3, 1'b0);
    repeat (LOOP_STEPS) send_item(OP_STEP, '0, '0, 1'b0);
    settle();

    $display("covered %0d loads, %0d starts, %0d steps, %0d unused opcodes; %0d beats checked",
             sb.op_seen[int'(OP_LOAD)], sb.op_seen[int'(OP_START)], sb.op_seen[int'(OP_STEP)],
             sb.op_seen[int'(OP_NONE)], sb.checked);
    $display("outcomes: moved %0d, exit %0d, blocked %0d, rejected %0d, done %0d; %s",
             sb.status_seen[int'(STAT_MOVED)], sb.status_seen[int'(STAT_EXIT)],
             sb.status_seen[int'(STAT_BLOCKED)], sb.status_seen[int'(STAT_REJECT)],
             sb.status_seen[int'(STAT_DONE)],
             sb.saturated ? "step total saturated" : "step total never saturated");
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
